// ===== src/bdef_pkg.sv =====
// ----------------------------------------------------------------------------
// bdef_pkg
// Types and constants shared by the byte difference extent finder modules.
// ----------------------------------------------------------------------------
package bdef_pkg;

	localparam int PAGE_W = 25;
	localparam int GAP_W  = 16;
	localparam int LEN_W  = 25;
	localparam int RUN_W  = 17;
	localparam int CFG_W  = 25;
	localparam int CFG_IDX_W = 1;

	localparam logic [PAGE_W-1:0] PAGE_SIZE_RESET = PAGE_W'(4096);
	localparam logic [GAP_W-1:0]  MERGE_GAP_RESET = GAP_W'(12);
	localparam logic [RUN_W-1:0]  RUN_MAX         = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP = 1'b1;

	typedef struct packed {
		logic [7:0] ref_byte;
		logic [7:0] new_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic differ;
		logic last;
		logic page_last;
	} class_flags_t;

	localparam int FLAGS_W = $bits(class_flags_t);

endpackage

// ===== src/bdef_queue.sv =====
// ----------------------------------------------------------------------------
// bdef_queue
// Small synchronous FIFO built from registers; depth is a power of two.
// ----------------------------------------------------------------------------
module bdef_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/bdef_front.sv =====
// ----------------------------------------------------------------------------
// bdef_front
// Accepts byte pairs, tracks stream and page position, and classifies each
// pair as differing or equal, last of page and last of stream.
// ----------------------------------------------------------------------------
module bdef_front #(
	parameter int OFFSET_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  bdef_pkg::in_item_t              item,
	input  logic [bdef_pkg::PAGE_W-1:0]     page_bytes,
	output bdef_pkg::class_flags_t          flags,
	output logic [OFFSET_BITS-1:0]          pos
);
	import bdef_pkg::*;

	logic [OFFSET_BITS-1:0] byte_pos_q;
	logic [PAGE_W-1:0]      page_pos_q;
	logic [PAGE_W:0]        page_pos_inc;

	assign page_pos_inc    = {1'b0, page_pos_q} + (PAGE_W + 1)'(1);
	assign flags.differ    = (item.ref_byte != item.new_byte);
	assign flags.last      = item.stream_end;
	assign flags.page_last = (page_bytes == '0) || (page_pos_inc >= {1'b0, page_bytes});
	assign pos             = byte_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			page_pos_q <= '0;
		end else if (accept) begin
			if (flags.last) begin
				byte_pos_q <= '0;
				page_pos_q <= '0;
			end else begin
				byte_pos_q <= byte_pos_q + OFFSET_BITS'(1);
				page_pos_q <= flags.page_last ? '0 : page_pos_inc[PAGE_W-1:0];
			end
		end
	end

endmodule

// ===== src/bdef_back.sv =====
// ----------------------------------------------------------------------------
// bdef_back
// Builds extents from classified byte pairs and emits offset and length
// when an extent closes.
// ----------------------------------------------------------------------------
module bdef_back #(
	parameter int OFFSET_BITS = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  bdef_pkg::class_flags_t       flags,
	input  logic [OFFSET_BITS-1:0]       pos,
	input  logic [bdef_pkg::GAP_W-1:0]   merge_gap,
	output logic                         emit,
	output logic [OFFSET_BITS-1:0]       extent_offset,
	output logic [bdef_pkg::LEN_W-1:0]   extent_length
);
	import bdef_pkg::*;

	logic                   open_q;
	logic [OFFSET_BITS-1:0] begin_q;
	logic [OFFSET_BITS-1:0] finish_q;
	logic [RUN_W-1:0]       run_q;

	logic [RUN_W-1:0]       run_inc;
	logic                   open_now;
	logic                   gap_close;
	logic                   close;
	logic [OFFSET_BITS-1:0] begin_now;
	logic [OFFSET_BITS-1:0] finish_now;
	logic [OFFSET_BITS-1:0] span;

	always_comb begin
		run_inc    = (run_q != RUN_MAX) ? run_q + RUN_W'(1) : run_q;
		open_now   = flags.differ || open_q;
		begin_now  = (flags.differ && !open_q) ? pos : begin_q;
		finish_now = flags.differ ? pos + OFFSET_BITS'(1) : finish_q;
		gap_close  = !flags.differ && open_q && (run_inc > RUN_W'(merge_gap));
		close      = open_now && (gap_close || flags.page_last || flags.last);
		span       = finish_now - begin_now;
	end

	assign emit          = go && close;
	assign extent_offset = begin_now;
	assign extent_length = LEN_W'(span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			run_q  <= '0;
		end else if (go) begin
			if (close) begin
				open_q <= 1'b0;
				run_q  <= '0;
			end else begin
				open_q <= open_now;
				if (flags.differ) begin
					run_q <= '0;
				end else if (open_q) begin
					run_q <= run_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			begin_q  <= begin_now;
			finish_q <= finish_now;
		end
	end

endmodule

// ===== src/byte_diff_extent_finder_unit.sv =====
// ----------------------------------------------------------------------------
// byte_diff_extent_finder_unit
// Groups differing bytes of two streams into page-bounded extents.
// ----------------------------------------------------------------------------
// The unit takes one byte pair per clock cycle while full is low and reports
// each extent of differing bytes as an offset and a length. A request is
// classified in the cycle it is pushed and lands in a four-entry queue; the
// extent logic takes one entry per cycle while the result queue has room and
// writes a closed extent into a two-entry result queue, so a result passes
// both queues before it reaches the result ports. Throughput is one request
// per cycle, limited by the single extent update per entry, and it is
// sustained as long as results are popped as fast as they are produced.
// Configuration changes must be made while no request is in flight.
module byte_diff_extent_finder_unit #(
	parameter int OFFSET_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  bdef_pkg::in_item_t             item,
	output logic                           empty,
	input  logic                           pop,
	output logic [OFFSET_BITS-1:0]         extent_offset,
	output logic [bdef_pkg::LEN_W-1:0]     extent_length,
	input  logic                           cfg_we,
	input  logic [bdef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdef_pkg::CFG_W-1:0]     cfg_data
);
	import bdef_pkg::*;

	localparam int CQ_W = FLAGS_W + OFFSET_BITS;
	localparam int RQ_W = OFFSET_BITS + LEN_W;

	logic [PAGE_W-1:0]      page_bytes_q;
	logic [GAP_W-1:0]       merge_gap_q;

	class_flags_t           f_flags;
	logic [OFFSET_BITS-1:0] f_pos;
	logic                   accept;

	logic [CQ_W-1:0]        cq_data;
	logic                   cq_empty;
	class_flags_t           b_flags;
	logic [OFFSET_BITS-1:0] b_pos;

	logic                   rq_full;
	logic                   go;
	logic                   emit;
	logic [OFFSET_BITS-1:0] b_offset;
	logic [LEN_W-1:0]       b_length;
	logic [RQ_W-1:0]        rq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_SIZE_RESET;
			merge_gap_q  <= MERGE_GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAGE_SIZE: page_bytes_q <= cfg_data[PAGE_W-1:0];
				CFG_MERGE_GAP: merge_gap_q  <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	bdef_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.page_bytes (page_bytes_q),
		.flags      (f_flags),
		.pos        (f_pos)
	);

	bdef_queue #(.WIDTH(CQ_W), .DEPTH(4)) u_class_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data ({f_flags, f_pos}),
		.full    (full),
		.rd_en   (go),
		.rd_data (cq_data),
		.empty   (cq_empty)
	);

	assign b_flags = cq_data[CQ_W-1:OFFSET_BITS];
	assign b_pos   = cq_data[OFFSET_BITS-1:0];
	assign go      = !cq_empty && !rq_full;

	bdef_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.flags         (b_flags),
		.pos           (b_pos),
		.merge_gap     (merge_gap_q),
		.emit          (emit),
		.extent_offset (b_offset),
		.extent_length (b_length)
	);

	bdef_queue #(.WIDTH(RQ_W), .DEPTH(2)) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (emit),
		.wr_data ({b_offset, b_length}),
		.full    (rq_full),
		.rd_en   (pop),
		.rd_data (rq_data),
		.empty   (empty)
	);

	assign extent_offset = rq_data[RQ_W-1:LEN_W];
	assign extent_length = rq_data[LEN_W-1:0];

endmodule

// ===== dv/byte_diff_extent_finder_unit_test.sv =====
// ----------------------------------------------------------------------------
// byte_diff_extent_finder_unit_test
// Self-checking test of the byte difference extent finder. A short table of
// directed requests covers the field extremes, page and merge gap corner
// settings and closing at several reasons at once. Phases of random streams
// follow, each under its own page size and merge gap. Results are compared
// with an in-bench prediction of the extents, with random idling on both
// sides and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module byte_diff_extent_finder_unit_test;
	import bdef_pkg::*;

	localparam int OFS_W = 48;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [OFS_W-1:0] off;
		logic [LEN_W-1:0] len;
	} extent_t;

	typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		in_item_t               pair;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_W-1:0]       reg_val;
		logic                   has_ext;
		extent_t                ext;
	} step_row_t;

	localparam step_row_t DIRECTED [24] = '{
		'{ROW_PAIR, '{8'h00, 8'hFF, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'hFF, 8'h00, 1'b1}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd0, 25'd2}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_MERGE_GAP, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'hAA, 8'h55, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h12, 8'h12, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd0, 25'd1}},
		'{ROW_PAIR, '{8'h12, 8'h12, 1'b1}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'd1, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h00, 8'h01, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd0, 25'd1}},
		'{ROW_PAIR, '{8'h80, 8'h7F, 1'b1}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd1, 25'd1}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'hFF, 8'hFE, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd0, 25'd1}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'h1000000, 1'b0,
			'{48'd0, 25'd0}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_MERGE_GAP, 25'h000FFFF, 1'b0,
			'{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h00, 8'hFF, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h55, 8'h55, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h01, 8'h02, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_MERGE_GAP, 25'd1, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h03, 8'h04, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd1, 25'd4}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'd4, 1'b0, '{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'h10, 8'h20, 1'b0}, CFG_PAGE_SIZE, 25'd0, 1'b1, '{48'd7, 25'd1}},
		'{ROW_CFG,  '{8'h00, 8'h00, 1'b0}, CFG_PAGE_SIZE, 25'h1FFFFFF, 1'b0,
			'{48'd0, 25'd0}},
		'{ROW_PAIR, '{8'hFF, 8'hFF, 1'b1}, CFG_PAGE_SIZE, 25'd0, 1'b0, '{48'd0, 25'd0}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	in_item_t             item = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [OFS_W-1:0]     extent_offset;
	logic [LEN_W-1:0]     extent_length;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PAGE_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic [PAGE_W-1:0] cfg_page = PAGE_SIZE_RESET;
	logic [GAP_W-1:0]  cfg_gap = MERGE_GAP_RESET;
	logic [OFS_W-1:0]  cur_offset = '0;
	logic [PAGE_W-1:0] page_offset = '0;
	logic              span_open = 1'b0;
	logic [OFS_W-1:0]  span_first = '0;
	logic [OFS_W-1:0]  span_past = '0;
	logic [RUN_W-1:0]  same_count = '0;

	extent_t pending_extents [$];
	int      mismatch_cnt = 0;
	bit      send_idle_en = 1'b1;
	bit      take_idle_en = 1'b1;
	int      drain_hold = 0;

	byte_diff_extent_finder_unit #(.OFFSET_BITS(OFS_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.extent_offset(extent_offset),
		.extent_length(extent_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void predict_extent(input in_item_t pair, output bit closed,
			output extent_t ext);
		logic differ;
		logic page_end;
		logic close_now;
		differ = pair.ref_byte != pair.new_byte;
		page_end = (cfg_page == '0) || ({1'b0, page_offset} + 26'd1 >= {1'b0, cfg_page});
		close_now = 1'b0;
		closed = 1'b0;
		ext = '0;
		if (differ) begin
			if (!span_open) begin
				span_open = 1'b1;
				span_first = cur_offset;
			end
			span_past = cur_offset + 1'b1;
			same_count = '0;
		end else if (span_open) begin
			if (same_count != RUN_MAX)
				same_count = same_count + 1'b1;
			if (same_count > cfg_gap)
				close_now = 1'b1;
		end
		if (span_open && (page_end || pair.stream_end))
			close_now = 1'b1;
		if (close_now) begin
			ext.off = span_first;
			ext.len = LEN_W'(span_past - span_first);
			span_open = 1'b0;
			same_count = '0;
			closed = 1'b1;
		end
		if (pair.stream_end) begin
			cur_offset = '0;
			page_offset = '0;
		end else begin
			cur_offset = cur_offset + 1'b1;
			page_offset = page_end ? '0 : page_offset + 1'b1;
		end
	endfunction

	task automatic send_pair(input in_item_t pair, input bit typed_ok, input extent_t typed);
		bit      closed;
		extent_t ext;
		if (send_idle_en && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		item <= pair;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_extent(pair, closed, ext);
		if (typed_ok)
			pending_extents.push_back(typed);
		else if (closed)
			pending_extents.push_back(ext);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		push <= 1'b0;
		while (pending_extents.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAGE_SIZE)
			cfg_page = val[PAGE_W-1:0];
		else
			cfg_gap = val[GAP_W-1:0];
	endtask

	initial begin
		extent_t got;
		extent_t want;
		@(posedge arst_n);
		forever begin
			if (drain_hold != 0) begin
				pop <= 1'b0;
				repeat (drain_hold) @(posedge clk);
				drain_hold = 0;
			end else if (take_idle_en && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (!empty) begin
				got = '{extent_offset, extent_length};
				if (pending_extents.size() == 0) begin
					$display("%0t: result with no request pending: offset %h length %h",
						$time, got.off, got.len);
					mismatch_cnt++;
				end else begin
					want = pending_extents.pop_front();
					if (got.off !== want.off) begin
						$display("%0t: extent_offset expected %h, actual %h",
							$time, want.off, got.off);
						mismatch_cnt++;
					end
					if (got.len !== want.len) begin
						$display("%0t: extent_length expected %h, actual %h",
							$time, want.len, got.len);
						mismatch_cnt++;
					end
				end
			end
		end
	end

	initial begin
		in_item_t pair;
		int       page;
		int       gap;
		int       stream_len;
		int       sent;
		int       run_left;
		int       same_len;
		bit       in_diff;
		bit       noise;
		bit       differ;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < $size(DIRECTED); r++) begin
			if (DIRECTED[r].kind == ROW_CFG)
				write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
			else
				send_pair(DIRECTED[r].pair, DIRECTED[r].has_ext, DIRECTED[r].ext);
		end

		run_left = 0;
		in_diff = 1'b0;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					page = $urandom_range(2, 40);
					gap = $urandom_range(0, 3);
				end
				1: begin
					page = 1;
					gap = $urandom_range(0, 8);
				end
				2: begin
					page = 0;
					gap = 12;
				end
				3: begin
					page = 25'h1000000;
					gap = 65535;
				end
				4, 5: begin
					page = $urandom_range(4, 64);
					gap = 0;
				end
				6: begin
					page = 25'h1FFFFFF;
					gap = $urandom_range(1, 16);
				end
				default: begin
					page = $urandom_range(1, 64);
					gap = $urandom_range(0, 10);
				end
			endcase
			write_reg(CFG_PAGE_SIZE, CFG_W'(page));
			write_reg(CFG_MERGE_GAP, CFG_W'(gap));
			send_idle_en = ph < 8 && ph != 5 && ph % 3 != 1;
			take_idle_en = ph < 8 && ph % 3 != 2;
			if (ph == 5)
				drain_hold = 80;
			sent = 0;
			while (sent < 190) begin
				stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 90);
				noise = $urandom_range(0, 4) == 0;
				for (int j = 0; j < stream_len && sent < 190; j++) begin
					if (noise) begin
						differ = 1'($urandom_range(0, 1));
					end else begin
						if (run_left == 0) begin
							in_diff = !in_diff;
							case ($urandom_range(0, 3))
								0: same_len = gap + 1;
								1: same_len = gap;
								2: same_len = $urandom_range(1, gap + 1);
								default: same_len = $urandom_range(1, 3);
							endcase
							if (same_len < 1)
								same_len = 1;
							if (same_len > 64)
								same_len = 64;
							run_left = in_diff ? $urandom_range(1, 5) : same_len;
						end
						differ = in_diff;
						run_left--;
					end
					pair.ref_byte = 8'($urandom_range(0, 255));
					pair.new_byte = differ ? pair.ref_byte ^ 8'($urandom_range(1, 255))
						: pair.ref_byte;
					pair.stream_end = j == stream_len - 1;
					send_pair(pair, 1'b0, '0);
					sent++;
				end
			end
		end

		push <= 1'b0;
		while (pending_extents.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && pending_extents.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
src/bdef_pkg.sv
src/bdef_queue.sv
src/bdef_front.sv
src/bdef_back.sv
src/byte_diff_extent_finder_unit.sv
dv/byte_diff_extent_finder_unit_test.sv
